/* hdl/rgb2cmyk_pkg.sv */
package rgb2cmyk_pkg;

    localparam int CH_W      = 8;
    localparam int OUT_W     = 16;
    localparam int NUM_LANES = 4;
    // remainder of the long division stays below the divisor, 2 * 255
    localparam int REM_W     = 9;

    localparam int LANE_C = 0;
    localparam int LANE_M = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_K = 3;

    localparam logic [CH_W-1:0]  CH_MAX    = 8'd255;
    // black divides by 255; doubled for round-to-nearest
    localparam logic [REM_W-1:0] BLACK_DIV = 9'd510;

    typedef logic [CH_W-1:0]  t_chan;
    typedef logic [REM_W-1:0] t_rem;

endpackage

/* hdl/rgb2cmyk_prep.sv */
module rgb2cmyk_prep #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  rgb2cmyk_pkg::t_chan                     i_red,
    input  rgb2cmyk_pkg::t_chan                     i_green,
    input  rgb2cmyk_pkg::t_chan                     i_blue,
    output logic                                    o_valid,
    output rgb2cmyk_pkg::t_chan                     o_max,
    output rgb2cmyk_pkg::t_rem [3:0]                o_rem,
    output logic [3:0][FRAC_BITS-1:0]               o_sh
);
    import rgb2cmyk_pkg::*;

    // 2*d*FULL + den stays below 510 * 2^FRAC_BITS
    localparam int NUM_W = FRAC_BITS + REM_W;

    t_chan                      mx;
    t_chan                      mxe;
    t_chan [2:0]                ch;
    t_chan                      d;
    t_chan                      addt;
    logic [NUM_W-1:0]           num;
    t_rem  [NUM_LANES-1:0]      n_rem;
    logic [NUM_LANES-1:0][FRAC_BITS-1:0] n_sh;

    logic                       r_valid;
    t_chan                      r_max;
    t_rem  [NUM_LANES-1:0]      r_rem;
    logic [NUM_LANES-1:0][FRAC_BITS-1:0] r_sh;

    // numerator of round(d * FULL / den) is 2*d*FULL + den, over divisor 2*den;
    // FULL = 2^FRAC_BITS - 1, so the product is a shift and a subtract
    always_comb begin
        ch[LANE_C] = i_red;
        ch[LANE_M] = i_green;
        ch[LANE_Y] = i_blue;
        mx = i_red;
        if (i_green > mx) begin
            mx = i_green;
        end
        if (i_blue > mx) begin
            mx = i_blue;
        end
        // all-zero pixel: divide 1 by 2, inks come out zero
        mxe = (mx == '0) ? t_chan'(1) : mx;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (l == LANE_K) begin
                d    = CH_MAX - mx;
                addt = CH_MAX;
            end else begin
                d    = mx - ch[l];
                addt = mxe;
            end
            num = (NUM_W'(d) << (FRAC_BITS + 1)) - (NUM_W'(d) << 1) + NUM_W'(addt);
            n_rem[l] = num[FRAC_BITS+REM_W-1:FRAC_BITS];
            n_sh[l]  = num[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_max <= mxe;
            r_rem <= n_rem;
            r_sh  <= n_sh;
        end
    end

    assign o_valid = r_valid;
    assign o_max   = r_max;
    assign o_rem   = r_rem;
    assign o_sh    = r_sh;

endmodule

/* hdl/rgb2cmyk_divstep.sv */
module rgb2cmyk_divstep #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  rgb2cmyk_pkg::t_chan                     i_max,
    input  rgb2cmyk_pkg::t_rem [3:0]                i_rem,
    input  logic [3:0][FRAC_BITS-1:0]               i_sh,
    output logic                                    o_valid,
    output rgb2cmyk_pkg::t_chan                     o_max,
    output rgb2cmyk_pkg::t_rem [3:0]                o_rem,
    output logic [3:0][FRAC_BITS-1:0]               o_sh
);
    import rgb2cmyk_pkg::*;

    t_rem                       den;
    logic [REM_W:0]             trial;
    logic                       qbit;
    t_rem  [NUM_LANES-1:0]      n_rem;
    logic [NUM_LANES-1:0][FRAC_BITS-1:0] n_sh;

    logic                       r_valid;
    t_chan                      r_max;
    t_rem  [NUM_LANES-1:0]      r_rem;
    logic [NUM_LANES-1:0][FRAC_BITS-1:0] r_sh;

    // one restoring step per lane: numerator bits leave the top of the shift
    // word, quotient bits enter at the bottom
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            den   = (l == LANE_K) ? BLACK_DIV : {i_max, 1'b0};
            trial = {i_rem[l], i_sh[l][FRAC_BITS-1]};
            qbit  = (trial >= {1'b0, den});
            if (qbit) begin
                n_rem[l] = REM_W'(trial - {1'b0, den});
            end else begin
                n_rem[l] = trial[REM_W-1:0];
            end
            n_sh[l] = {i_sh[l][FRAC_BITS-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_max <= i_max;
            r_rem <= n_rem;
            r_sh  <= n_sh;
        end
    end

    assign o_valid = r_valid;
    assign o_max   = r_max;
    assign o_rem   = r_rem;
    assign o_sh    = r_sh;

endmodule

/* hdl/rgb_to_cmyk_converter.sv */
// RGB to CMYK pixel converter.
// Input stream s_axis: one 8-bit RGB pixel per item. Output stream m_axis:
// one CMYK item per pixel, each field an unsigned fraction with full scale
// 2^FRAC_BITS - 1, low 16 bits delivered. black = (255 - max) / 255 and
// each ink = (max - channel) / max, rounded to nearest, ties up; a black
// pixel gives full black and zero inks.
// Pipeline: one stage finds the max channel and forms the numerators, then
// FRAC_BITS restoring-division stages produce one quotient bit each for all
// four fields in parallel. Throughput is one pixel per clock while
// m_axis_tready stays high; pixels are independent.
// Stalls: each stage advances when it is empty or the stage after it moves,
// so bubbles are squeezed out and s_axis_tready stays high until every stage
// holds an item. While m_axis_tready is low the last stage holds its item.
// Reset (i_rst_n low, synchronous) empties the pipeline; data registers are
// not cleared.
module rgb_to_cmyk_converter #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // cyan, magenta, yellow, black; 16 bits each
);
    import rgb2cmyk_pkg::*;

    localparam int NUM_STG = FRAC_BITS + 1;

    logic  [NUM_STG-1:0]                            stg_valid;
    logic  [NUM_STG-1:0]                            stg_adv;
    t_chan [NUM_STG-1:0]                            stg_max;
    t_rem  [NUM_STG-1:0][NUM_LANES-1:0]             stg_rem;
    logic  [NUM_STG-1:0][NUM_LANES-1:0][FRAC_BITS-1:0] stg_sh;
    logic  [NUM_LANES-1:0][OUT_W-1:0]               res;

    // a stage may load when it is empty or its content moves on
    always_comb begin
        stg_adv[NUM_STG-1] = !stg_valid[NUM_STG-1] || m_axis_tready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            stg_adv[k] = !stg_valid[k] || stg_adv[k+1];
        end
    end

    assign s_axis_tready = stg_adv[0];

    rgb2cmyk_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (stg_adv[0]),
        .i_valid (s_axis_tvalid),
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .o_valid (stg_valid[0]),
        .o_max   (stg_max[0]),
        .o_rem   (stg_rem[0]),
        .o_sh    (stg_sh[0])
    );

    for (genvar k = 1; k < NUM_STG; k++) begin : g_div
        rgb2cmyk_divstep #(
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (stg_adv[k]),
            .i_valid (stg_valid[k-1]),
            .i_max   (stg_max[k-1]),
            .i_rem   (stg_rem[k-1]),
            .i_sh    (stg_sh[k-1]),
            .o_valid (stg_valid[k]),
            .o_max   (stg_max[k]),
            .o_rem   (stg_rem[k]),
            .o_sh    (stg_sh[k])
        );
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_res
        if (FRAC_BITS >= OUT_W) begin : g_trunc
            assign res[l] = stg_sh[NUM_STG-1][l][OUT_W-1:0];
        end else begin : g_ext
            assign res[l] = OUT_W'(stg_sh[NUM_STG-1][l]);
        end
    end

    assign m_axis_tvalid = stg_valid[NUM_STG-1];
    assign m_axis_tdata  = {res[LANE_K], res[LANE_Y], res[LANE_M], res[LANE_C]};

endmodule
